>>> src/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Payload structs, register map and the pattern length clamp.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int unsigned MaxPatternBytes = 16;
  localparam int unsigned PatStoreBytes   = 16;
  localparam int unsigned NumCells =
    (MaxPatternBytes < PatStoreBytes) ? MaxPatternBytes : PatStoreBytes;
  // Previous bytes kept in the window, one per cell
  localparam int unsigned WinDepth = MaxPatternBytes - 1;
  localparam int unsigned CellIdxW = (NumCells > 1) ? $clog2(NumCells) : 1;
  localparam int unsigned AddrW    = 24;
  localparam int unsigned LenW     = 5;
  localparam int unsigned PaddrW   = 6;
  localparam int unsigned PdataW   = 64;
  localparam logic [7:0]  DontCare = 8'hFF;

  // Register indexes (byte address is 8 times the index)
  typedef enum logic [2:0] {
    RegPatternLow    = 3'd0,
    RegPatternHigh   = 3'd1,
    RegPatternLength = 3'd2,
    RegRegionStart   = 3'd3,
    RegRegionEnd     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       scan_start;
  } in_t;

  typedef struct packed {
    logic             match_found;
    logic [AddrW-1:0] match_address;
  } out_t;

  typedef struct packed {
    logic [63:0]      pattern_low;
    logic [63:0]      pattern_high;
    logic [LenW-1:0]  pattern_length;
    logic [AddrW-1:0] region_start;
    logic [AddrW-1:0] region_end;
  } cfg_t;

  // Per-cycle control that every cell sees
  typedef struct packed {
    logic advance;  // a word is accepted this cycle
    logic flush;    // address wraps: forget the window history
  } cell_ctl_t;

  // Clamp the programmed length to 1..NumCells, return length minus one
  function automatic logic [CellIdxW-1:0] len_minus_one(logic [LenW-1:0] len);
    logic [LenW:0] n;
    n = {1'b0, len};
    if (n == '0) begin
      n = (LenW+1)'(1);
    end
    if (n > (LenW+1)'(NumCells)) begin
      n = (LenW+1)'(NumCells);
    end
    return CellIdxW'(n - (LenW+1)'(1));
  endfunction

endpackage

>>> src/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell: one slot of the byte window
// Holds one previous byte and whether it belongs to the current scan, hands
// both to the older neighbor, and compares the byte with its pattern byte.
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wbps_pkg::cell_ctl_t   ctl_i,
  input  logic [7:0]            byte_i,     // byte from the newer neighbor
  input  logic                  valid_i,    // that byte belongs to this scan
  input  logic [7:0]            pat_i,      // pattern byte lined up with this slot
  input  logic                  wild_en_i,  // 0xFF may act as don't-care here
  output logic [7:0]            byte_o,
  output logic                  valid_o,
  output logic                  hit_o       // held byte matches pat_i
);

  logic [7:0] byte_q;
  logic       valid_d;
  logic       valid_q;

  // Compare the held byte against the lined-up pattern byte
  assign hit_o   = (wild_en_i && (pat_i == wbps_pkg::DontCare)) || (pat_i == byte_q);
  assign valid_d = valid_i && !ctl_i.flush;

  // Shift the window by one slot per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= 8'h00;
      valid_q <= 1'b0;
    end else if (ctl_i.advance) begin
      byte_q  <= byte_i;
      valid_q <= valid_d;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

>>> src/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg: configuration register file
// APB-style slave holding the pattern, its length and the scan region.
// ----------------------------------------------------------------------------
module wbps_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbps_pkg::PaddrW-1:0]  paddr,
  input  logic [wbps_pkg::PdataW-1:0]  pwdata,
  output logic [wbps_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output wbps_pkg::cfg_t               cfg_o
);

  wbps_pkg::cfg_t   cfg_q;
  wbps_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = wbps_pkg::reg_idx_e'(paddr[wbps_pkg::PaddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the addressed register in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.pattern_length <= wbps_pkg::LenW'(16);
      cfg_q.region_start   <= '0;
      cfg_q.region_end     <= '1;
    end else if (wr_en) begin
      case (idx)
        wbps_pkg::RegPatternLow: begin
          cfg_q.pattern_low <= pwdata;
        end
        wbps_pkg::RegPatternHigh: begin
          cfg_q.pattern_high <= pwdata;
        end
        wbps_pkg::RegPatternLength: begin
          cfg_q.pattern_length <= pwdata[wbps_pkg::LenW-1:0];
        end
        wbps_pkg::RegRegionStart: begin
          cfg_q.region_start <= pwdata[wbps_pkg::AddrW-1:0];
        end
        wbps_pkg::RegRegionEnd: begin
          cfg_q.region_end <= pwdata[wbps_pkg::AddrW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (idx)
      wbps_pkg::RegPatternLow:    prdata = cfg_q.pattern_low;
      wbps_pkg::RegPatternHigh:   prdata = cfg_q.pattern_high;
      wbps_pkg::RegPatternLength: prdata = wbps_pkg::PdataW'(cfg_q.pattern_length);
      wbps_pkg::RegRegionStart:   prdata = wbps_pkg::PdataW'(cfg_q.region_start);
      wbps_pkg::RegRegionEnd:     prdata = wbps_pkg::PdataW'(cfg_q.region_end);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/wildcard_byte_pattern_scanner_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_top: byte stream signature search
// Looks for a pattern of up to 16 bytes with 0xFF don't-care bytes after the first.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_data_i) carries one image
//   byte per word, with scan_start marking the first byte of a scan; that
//   byte gets address region_start. Every accepted word yields exactly one
//   result word on the output channel: match_found and the start address
//   of a match that ends at this byte and lies wholly inside
//   [region_start, region_end).
//   The result is registered in the output register, or in the skid
//   register while the output stalls. Throughput is one word per cycle
//   while the receiver does not stall, through the cell chain, one cell per
//   window byte, each passing its byte to the next while all compare at once.
//   When the receiver stalls, one more word is taken into a skid register
//   and in_ready_o then drops until the output drains.
//   Reset clears the chain, the address counter and both output stages and
//   loads the register defaults (length 16, full address region). The user
//   writes registers over the APB port with no word in flight; not enforced.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbps_pkg::PaddrW-1:0]  paddr,
  input  logic [wbps_pkg::PdataW-1:0]  pwdata,
  output logic [wbps_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  wbps_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output wbps_pkg::out_t               out_data_o
);

  localparam int unsigned N  = wbps_pkg::NumCells;
  localparam int unsigned W  = wbps_pkg::WinDepth;
  localparam int unsigned AW = wbps_pkg::AddrW;

  wbps_pkg::cfg_t      cfg;
  wbps_pkg::cell_ctl_t cell_ctl;
  logic                in_fire;
  logic [W-1:0][7:0]   cell_byte;
  logic [W-1:0][7:0]   cell_byte_in;
  logic [W-1:0]        cell_valid;
  logic [W-1:0]        cell_valid_in;
  logic [W-1:0]        win_valid;
  logic [W-1:0]        cell_hit;
  logic [7:0]          cur_pat;
  logic                cur_hit;
  logic                chain_ok;
  logic [127:0]        pat_bytes;
  logic [wbps_pkg::CellIdxW-1:0] len_m1;
  logic [AW-1:0]       position_d, position_q;
  logic [AW-1:0]       addr;
  logic [AW-1:0]       first;
  logic                hit;
  wbps_pkg::out_t      result;
  wbps_pkg::out_t      out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                out_fire;

  // Configuration registers
  wbps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign pat_bytes  = {cfg.pattern_high, cfg.pattern_low};
  assign len_m1     = wbps_pkg::len_minus_one(cfg.pattern_length);

  // Address of the current byte; a scan start restarts at region_start
  assign addr       = in_data_i.scan_start ? cfg.region_start : position_q;
  assign position_d = addr + AW'(1);

  assign cell_ctl.advance = in_fire;
  assign cell_ctl.flush   = (position_d == '0);

  // Build the window chain; a scan start drops every held byte
  for (genvar k = 0; k < W; k++) begin : g_cell
    logic [wbps_pkg::CellIdxW-1:0] pidx;
    logic [7:0]                    pat_sel;
    // slot k holds the byte k+1 places before the current one
    assign pidx    = len_m1 - wbps_pkg::CellIdxW'(k + 1);
    assign pat_sel = pat_bytes[{pidx, 3'b000} +: 8];
    if (k == 0) begin : g_head
      assign cell_byte_in[k]  = in_data_i.data_byte;
      assign cell_valid_in[k] = 1'b1;
    end else begin : g_body
      assign cell_byte_in[k]  = cell_byte[k-1];
      assign cell_valid_in[k] = win_valid[k-1];
    end
    assign win_valid[k] = cell_valid[k] && !in_data_i.scan_start;
    wbps_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (cell_ctl),
      .byte_i    (cell_byte_in[k]),
      .valid_i   (cell_valid_in[k]),
      .pat_i     (pat_sel),
      .wild_en_i (pidx != '0),
      .byte_o    (cell_byte[k]),
      .valid_o   (cell_valid[k]),
      .hit_o     (cell_hit[k])
    );
  end

  // Compare the current byte with the last pattern byte
  assign cur_pat = pat_bytes[{len_m1, 3'b000} +: 8];
  assign cur_hit = ((len_m1 != '0) && (cur_pat == wbps_pkg::DontCare)) ||
                   (cur_pat == in_data_i.data_byte);

  // Every slot inside the pattern length must hold a matching scan byte
  always_comb begin
    chain_ok = cur_hit;
    for (int m = 1; m < N; m++) begin
      if ((wbps_pkg::CellIdxW'(m) <= len_m1) && !(win_valid[m-1] && cell_hit[m-1])) begin
        chain_ok = 1'b0;
      end
    end
  end

  // Check the full pattern and the region bounds
  assign first = addr - AW'(len_m1);
  assign hit   = chain_ok && (addr >= AW'(len_m1)) &&
                 (first >= cfg.region_start) && (addr < cfg.region_end);
  assign result.match_found   = hit;
  assign result.match_address = hit ? first : '0;

  // Track the address of the next byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
    end else if (in_fire) begin
      position_q <= position_d;
    end
  end

  // Output register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= result;
      end
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid stage only fills behind a stalled output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  // A stalled output word plus a new word fills the skid stage
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && in_fire) |=> skid_valid_q)
    else $error("word lost while output stalled");

  // A scan start places the next byte right after region_start
  a_scan_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.scan_start) |=>
      (position_q == $past(cfg.region_start) + AW'(1)))
    else $error("position not restarted at region start");

  // No match is reported with an address below the region or ending past its end
  a_match_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && hit) |-> (first >= cfg.region_start && addr < cfg.region_end))
    else $error("match outside region");

endmodule
